>>> sv/flvd_pkg.sv
// shared types, constants and helpers for the flv tag deframer
package flvd_pkg;

    localparam logic [23:0] SIGNATURE = 24'h464C56;
    localparam int QueueDepth = 4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_WARN    = 2'd2;

    localparam logic [7:0] TAG_AUDIO  = 8'd8;
    localparam logic [7:0] TAG_VIDEO  = 8'd9;
    localparam logic [7:0] TAG_SCRIPT = 8'd18;

    typedef enum logic [3:0] {
        PH_SEARCH  = 4'd0,
        PH_FLAGS   = 4'd1,
        PH_HSIZE   = 4'd2,
        PH_SKIP    = 4'd3,
        PH_DSIZE   = 4'd4,
        PH_TIME    = 4'd5,
        PH_TRACK   = 4'd6,
        PH_MEDIA   = 4'd7,
        PH_PAYLOAD = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag_type;
        logic [31:0] timestamp;
        logic [15:0] track;
        logic [3:0]  codec;
        logic [3:0]  frame_type;
        logic        is_config;
        logic [23:0] composition_offset;
        logic [15:0] sample_rate;
        logic [1:0]  channels;
        logic [7:0]  payload_byte;
        logic        last;
    } out_item_t;

    // audio rate bits to hertz
    function automatic logic [15:0] rate_hz(input logic [1:0] code);
        logic [15:0] r;
        begin
            case (code)
                2'd0:    r = 16'd5512;
                2'd1:    r = 16'd11025;
                2'd2:    r = 16'd22050;
                default: r = 16'd44100;
            endcase
            return r;
        end
    endfunction

endpackage

>>> sv/flvd_parser.sv
// front end: byte parser that classifies each byte and builds result items
module flvd_parser
    import flvd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      step,
    output logic      res_valid,
    output out_item_t res_item
);

    phase_t      phase_reg, phase_next;
    logic [31:0] left_reg, left_next;
    logic [23:0] win_reg, win_next;
    logic [7:0]  ttype_reg, ttype_next;
    logic [31:0] time_reg, time_next;
    logic [23:0] track_reg, track_next;
    logic [7:0]  mflags_reg, mflags_next;
    logic [23:0] offs_reg, offs_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic        warned_reg, warned_next;
    logic        avccfg_reg, avccfg_next;

    logic [7:0]  b;
    logic [31:0] dec;
    logic [23:0] acc;
    logic        audio;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEARCH;
            left_reg   <= '0;
            win_reg    <= '0;
            ttype_reg  <= '0;
            time_reg   <= '0;
            track_reg  <= '0;
            mflags_reg <= '0;
            offs_reg   <= '0;
            hidx_reg   <= '0;
            warned_reg <= 1'b0;
            avccfg_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            win_reg    <= win_next;
            ttype_reg  <= ttype_next;
            time_reg   <= time_next;
            track_reg  <= track_next;
            mflags_reg <= mflags_next;
            offs_reg   <= offs_next;
            hidx_reg   <= hidx_next;
            warned_reg <= warned_next;
            avccfg_reg <= avccfg_next;
        end
    end

    // next state and result for one byte
    always_comb
    begin
        b = in_item.data_byte;
        phase_next  = phase_reg;
        left_next   = left_reg;
        win_next    = win_reg;
        ttype_next  = ttype_reg;
        time_next   = time_reg;
        track_next  = track_reg;
        mflags_next = mflags_reg;
        offs_next   = offs_reg;
        hidx_next   = hidx_reg;
        warned_next = warned_reg;
        avccfg_next = avccfg_reg;
        res_valid   = 1'b0;
        res_item    = '0;
        res_item.tag_type  = ttype_reg;
        res_item.timestamp = time_reg;
        res_item.track     = track_reg[15:0];
        dec   = left_reg - 32'd1;
        acc   = {offs_reg[15:0], b};
        audio = (ttype_reg == TAG_AUDIO);

        if (in_item.flush)
        begin
            phase_next  = PH_SEARCH;
            left_next   = '0;
            win_next    = '0;
            hidx_next   = '0;
            warned_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    win_next = {win_reg[15:0], b};
                    if (hidx_reg < 3'd3)
                        hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg >= 3'd2)
                    begin
                        if ({win_reg[15:0], b} == SIGNATURE)
                        begin
                            warned_next = 1'b0;
                            win_next    = '0;
                            hidx_next   = '0;
                            phase_next  = PH_FLAGS;
                        end
                        else if (!warned_reg)
                        begin
                            warned_next = 1'b1;
                            res_valid   = 1'b1;
                            res_item    = '0;
                            res_item.kind = KIND_WARN;
                        end
                    end
                end
                PH_FLAGS:
                begin
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg >= 3'd1)
                    begin
                        hidx_next  = '0;
                        left_next  = '0;
                        phase_next = PH_HSIZE;
                    end
                end
                PH_HSIZE:
                begin
                    left_next = {left_reg[23:0], b};
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg >= 3'd3)
                    begin
                        hidx_next  = '0;
                        left_next  = ({left_reg[23:0], b} > 32'd9) ?
                                     {left_reg[23:0], b} - 32'd5 : 32'd4;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (left_reg != '0)
                        left_next = dec;
                    else
                    begin
                        ttype_next = b;
                        hidx_next  = '0;
                        phase_next = PH_DSIZE;
                    end
                end
                PH_DSIZE:
                begin
                    left_next = {8'd0, left_reg[15:0], b};
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg >= 3'd2)
                    begin
                        hidx_next  = '0;
                        time_next  = '0;
                        phase_next = PH_TIME;
                    end
                end
                PH_TIME:
                begin
                    if (hidx_reg < 3'd3)
                        time_next = {8'd0, time_reg[15:0], b};
                    else
                        time_next = {b, time_reg[23:0]};
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg >= 3'd3)
                    begin
                        hidx_next  = '0;
                        track_next = '0;
                        phase_next = PH_TRACK;
                    end
                end
                PH_TRACK:
                begin
                    track_next = {track_reg[15:0], b};
                    hidx_next  = hidx_reg + 3'd1;
                    if (hidx_reg >= 3'd2)
                    begin
                        hidx_next = '0;
                        res_item.track = {track_reg[7:0], b};
                        if (ttype_reg == TAG_AUDIO || ttype_reg == TAG_VIDEO)
                        begin
                            if (left_reg != '0)
                                phase_next = PH_MEDIA;
                            else
                            begin
                                res_valid = 1'b1;
                                res_item.is_config = audio;
                                res_item.last = 1'b1;
                                phase_next = PH_SKIP;
                                left_next  = 32'd4;
                            end
                        end
                        else if (ttype_reg == TAG_SCRIPT)
                        begin
                            res_valid = 1'b1;
                            res_item.last = (left_reg == '0);
                            if (left_reg != '0)
                                phase_next = PH_PAYLOAD;
                            else
                            begin
                                phase_next = PH_SKIP;
                                left_next  = 32'd4;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                            left_next  = left_reg + 32'd4;
                        end
                    end
                end
                PH_MEDIA:
                begin
                    if (left_reg == '0)
                    begin
                        phase_next = PH_SKIP;
                        left_next  = 32'd4;
                    end
                    else
                    begin
                        left_next = dec;
                        // header result fields, used when one is produced
                        if (audio)
                        begin
                            res_item.codec       = (hidx_reg == '0) ? b[7:4] : mflags_reg[7:4];
                            res_item.sample_rate = rate_hz((hidx_reg == '0) ?
                                                   b[3:2] : mflags_reg[3:2]);
                            res_item.channels    = {1'b0, (hidx_reg == '0) ?
                                                   b[0] : mflags_reg[0]} + 2'd1;
                        end
                        else
                        begin
                            res_item.codec      = (hidx_reg == '0) ? b[3:0] : mflags_reg[3:0];
                            res_item.frame_type = (hidx_reg == '0) ? b[7:4] : mflags_reg[7:4];
                        end
                        res_item.last = (dec == '0);
                        if (hidx_reg == '0)
                        begin
                            mflags_next = b;
                            if (audio)
                            begin
                                if (b[7:4] == 4'd10 && dec != '0)
                                    hidx_next = 3'd1;
                                else
                                    res_valid = 1'b1;
                            end
                            else if (b[3:0] != 4'd7)
                                res_valid = 1'b1;
                            else if (dec == '0)
                            begin
                                res_valid = 1'b1;
                                res_item.is_config = 1'b1;
                            end
                            else
                                hidx_next = 3'd1;
                        end
                        else if (audio)
                        begin
                            res_valid = 1'b1;
                            res_item.is_config = (b == 8'd0);
                        end
                        else if (hidx_reg == 3'd1)
                        begin
                            avccfg_next = (b == 8'd0);
                            offs_next   = '0;
                            res_item.is_config = (b == 8'd0);
                            if (dec == '0)
                                res_valid = 1'b1;
                            else
                                hidx_next = 3'd2;
                        end
                        else
                        begin
                            offs_next = acc;
                            res_item.is_config = avccfg_reg;
                            if (hidx_reg >= 3'd4 || dec == '0)
                            begin
                                res_valid = 1'b1;
                                case (hidx_reg)
                                    3'd2:    res_item.composition_offset = {acc[7:0], 16'd0};
                                    3'd3:    res_item.composition_offset = {acc[15:0], 8'd0};
                                    default: res_item.composition_offset = acc;
                                endcase
                            end
                            else
                                hidx_next = hidx_reg + 3'd1;
                        end
                        if (res_valid)
                        begin
                            if (dec != '0)
                                phase_next = PH_PAYLOAD;
                            else
                            begin
                                phase_next = PH_SKIP;
                                left_next  = 32'd4;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    res_item.kind = KIND_PAYLOAD;
                    res_item.payload_byte = b;
                    left_next = (left_reg != '0) ? dec : '0;
                    res_item.last = (left_reg <= 32'd1);
                    if (left_reg <= 32'd1)
                    begin
                        phase_next = PH_SKIP;
                        left_next  = 32'd4;
                    end
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                    hidx_next  = '0;
                end
            endcase
        end
    end

    // track index stays in range, payload phase has bytes left, flush restarts search
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TRACK |-> hidx_reg <= 3'd2)
        else $error("track index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != '0)
        else $error("payload phase with nothing left");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && in_item.flush |=> phase_reg == PH_SEARCH && hidx_reg == '0)
        else $error("flush did not restart search");

endmodule

>>> sv/flvd_queue.sv
// back end: short result queue that drives the output channel
module flvd_queue
    import flvd_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      space,
    output logic      valid,
    input  logic      ready,
    output out_item_t item
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    out_item_t       mem_reg [Depth];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            pop;

    assign valid = (cnt_reg != '0);
    assign item  = mem_reg[rp_reg];
    assign pop   = valid && ready;
    assign space = (cnt_reg < (AW+1)'(Depth)) || pop;

    // write storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + AW'(1);
            if (pop)
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(Depth))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("push without space");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("queued transfer lost");

endmodule

>>> sv/flv_tag_deframer.sv
// top level of the flv tag deframer
// Use: feed the FLV stream one byte per input transfer on in_valid/in_ready
// (in_item.data_byte, in_item.flush). A flush byte restarts signature search
// and gives no result. Each input byte gives zero or one result on
// out_valid/out_ready: a tag header (kind 0), a payload byte (kind 1) or a
// one-time signature warning (kind 2); last marks a tag's final result.
// A result enters the queue when its byte is accepted, behind earlier results.
// Throughput: one byte per cycle while in_ready is high; the parser updates its
// state once per accepted byte and writes results into a small queue.
// When the receiver stalls the queue fills; in_ready drops only when the
// queue is full and nothing leaves it in that cycle.
// Reset: asynchronous, parser returns to signature search, queue empties.
module flv_tag_deframer
    import flvd_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      step;
    logic      res_valid;
    out_item_t res_item;
    logic      space;

    assign in_ready = space;
    assign step     = in_valid && in_ready;

    flvd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .step      (step),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    flvd_queue #(.Depth(Depth)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_item (res_item),
        .space     (space),
        .valid     (out_valid),
        .ready     (out_ready),
        .item      (out_item)
    );

endmodule

>>> verif/flv_tag_deframer_tb.sv
// testbench for the flv tag deframer: directed table, random streams, self-checking predictor
module flv_tag_deframer_tb;
    import flvd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    flv_tag_deframer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    // parser state mirror
    phase_t      p_phase;
    logic [31:0] p_left;
    logic [23:0] p_window;
    logic [7:0]  p_type;
    logic [31:0] p_time;
    logic [23:0] p_track;
    logic [7:0]  p_flags;
    logic [23:0] p_offset;
    logic [2:0]  p_index;
    logic        p_warned;
    logic        p_avc_cfg;

    out_item_t expected_results[$];
    in_item_t  byte_stream[$];
    int        fail_count;
    int        cycle_count = 0;
    logic      hold_off;

    // directed rows: byte, flush, whether a typed-in result follows, that result
    typedef struct {
        logic [7:0] b;
        logic       fl;
        logic       typed;
        out_item_t  res;
    } row_t;

    function automatic out_item_t base_result(logic [1:0] k);
        out_item_t r;
        r = '0;
        r.kind = k;
        r.tag_type = p_type;
        r.timestamp = p_time;
        r.track = p_track[15:0];
        return r;
    endfunction

    function automatic logic [15:0] audio_rate(logic [1:0] c);
        logic [15:0] hz;
        case (c)
            2'd0:    hz = 16'd5512;
            2'd1:    hz = 16'd11025;
            2'd2:    hz = 16'd22050;
            default: hz = 16'd44100;
        endcase
        return hz;
    endfunction

    function automatic void end_of_header();
        if (p_left != 0)
            p_phase = PH_PAYLOAD;
        else
        begin
            p_phase = PH_SKIP;
            p_left = 4;
        end
    endfunction

    function automatic out_item_t audio_header(logic cfg);
        out_item_t r;
        r = base_result(KIND_HEADER);
        r.codec = p_flags[7:4];
        r.is_config = cfg;
        r.sample_rate = audio_rate(p_flags[3:2]);
        r.channels = {1'b0, p_flags[0]} + 2'd1;
        r.last = (p_left == 0);
        end_of_header();
        return r;
    endfunction

    function automatic out_item_t video_header(logic cfg, logic [23:0] comp);
        out_item_t r;
        r = base_result(KIND_HEADER);
        r.codec = p_flags[3:0];
        r.frame_type = p_flags[7:4];
        r.is_config = cfg;
        r.composition_offset = comp;
        r.last = (p_left == 0);
        end_of_header();
        return r;
    endfunction

    function automatic void parser_reset();
        p_phase = PH_SEARCH;
        p_left = 0; p_window = 0; p_type = 0; p_time = 0; p_track = 0;
        p_flags = 0; p_offset = 0; p_index = 0; p_warned = 0; p_avc_cfg = 0;
    endfunction

    // media header byte of an audio or video tag
    function automatic logic media_step(logic [7:0] b, output out_item_t r);
        logic        audio;
        logic [4:0]  sh;
        audio = (p_type == TAG_AUDIO);
        p_left = p_left - 1;
        if (p_index == 0)
        begin
            p_flags = b;
            if (audio)
            begin
                if (b[7:4] == 4'd10 && p_left != 0)
                begin
                    p_index = 3'd1;
                    return 0;
                end
                r = audio_header(1'b0);
                return 1;
            end
            if (b[3:0] != 4'd7)
            begin
                r = video_header(1'b0, 24'd0);
                return 1;
            end
            if (p_left == 0)
            begin
                r = video_header(1'b1, 24'd0);
                return 1;
            end
            p_index = 3'd1;
            return 0;
        end
        if (audio)
        begin
            r = audio_header(b == 0);
            return 1;
        end
        if (p_index == 1)
        begin
            p_avc_cfg = (b == 0);
            p_offset = 0;
            if (p_left == 0)
            begin
                r = video_header(p_avc_cfg, 24'd0);
                return 1;
            end
            p_index = 3'd2;
            return 0;
        end
        p_offset = {p_offset[15:0], b};
        if (p_index >= 4 || p_left == 0)
        begin
            sh = (p_index >= 4) ? 5'd0 : 5'(8 * (4 - p_index));
            r = video_header(p_avc_cfg, p_offset << sh);
            return 1;
        end
        p_index = p_index + 3'd1;
        return 0;
    endfunction

    // one accepted byte; returns whether it yields a result
    function automatic logic parse_byte(in_item_t it, output out_item_t r);
        logic [7:0] b;
        b = it.data_byte;
        r = '0;
        if (it.flush)
        begin
            p_phase = PH_SEARCH; p_left = 0; p_window = 0; p_index = 0; p_warned = 0;
            return 0;
        end
        case (p_phase)
            PH_SEARCH:
            begin
                p_window = {p_window[15:0], b};
                if (p_index < 3) p_index = p_index + 3'd1;
                if (p_index < 3) return 0;
                if (p_window == SIGNATURE)
                begin
                    p_warned = 0; p_window = 0; p_index = 0; p_phase = PH_FLAGS;
                    return 0;
                end
                if (p_warned) return 0;
                p_warned = 1;
                r.kind = KIND_WARN;
                return 1;
            end
            PH_FLAGS:
            begin
                p_index = p_index + 3'd1;
                if (p_index >= 2)
                begin
                    p_index = 0; p_left = 0; p_phase = PH_HSIZE;
                end
                return 0;
            end
            PH_HSIZE:
            begin
                p_left = {p_left[23:0], b};
                p_index = p_index + 3'd1;
                if (p_index >= 4)
                begin
                    p_index = 0;
                    p_left = (p_left > 9) ? p_left - 5 : 32'd4;
                    p_phase = PH_SKIP;
                end
                return 0;
            end
            PH_SKIP:
            begin
                if (p_left != 0)
                begin
                    p_left = p_left - 1;
                    return 0;
                end
                p_type = b; p_index = 0; p_phase = PH_DSIZE;
                return 0;
            end
            PH_DSIZE:
            begin
                p_left = {8'd0, p_left[15:0], b};
                p_index = p_index + 3'd1;
                if (p_index >= 3)
                begin
                    p_index = 0; p_time = 0; p_phase = PH_TIME;
                end
                return 0;
            end
            PH_TIME:
            begin
                if (p_index < 3)
                    p_time = {8'd0, p_time[15:0], b};
                else
                    p_time[31:24] = p_time[31:24] | b;
                p_index = p_index + 3'd1;
                if (p_index >= 4)
                begin
                    p_index = 0; p_track = 0; p_phase = PH_TRACK;
                end
                return 0;
            end
            PH_TRACK:
            begin
                p_track = {p_track[15:0], b};
                p_index = p_index + 3'd1;
                if (p_index < 3) return 0;
                p_index = 0;
                if (p_type == TAG_AUDIO || p_type == TAG_VIDEO)
                begin
                    if (p_left != 0)
                    begin
                        p_phase = PH_MEDIA;
                        return 0;
                    end
                    r = base_result(KIND_HEADER);
                    r.is_config = (p_type == TAG_AUDIO);
                    r.last = 1;
                    end_of_header();
                    return 1;
                end
                if (p_type == TAG_SCRIPT)
                begin
                    r = base_result(KIND_HEADER);
                    r.last = (p_left == 0);
                    end_of_header();
                    return 1;
                end
                p_phase = PH_SKIP;
                p_left = p_left + 4;
                return 0;
            end
            PH_MEDIA:
            begin
                if (p_left == 0)
                begin
                    end_of_header();
                    return 0;
                end
                return media_step(b, r);
            end
            PH_PAYLOAD:
            begin
                if (p_left != 0) p_left = p_left - 1;
                r = base_result(KIND_PAYLOAD);
                r.payload_byte = b;
                r.last = (p_left == 0);
                if (p_left == 0)
                begin
                    p_phase = PH_SKIP;
                    p_left = 4;
                end
                return 1;
            end
            default:
            begin
                p_phase = PH_SEARCH;
                p_index = 0;
                return 0;
            end
        endcase
    endfunction

    // stream builders
    function automatic void push_byte(logic [7:0] b);
        in_item_t it;
        it.data_byte = b;
        it.flush = 1'b0;
        byte_stream.push_back(it);
    endfunction

    function automatic void push_file_header(int hsize);
        push_byte(8'h46); push_byte(8'h4C); push_byte(8'h56);
        push_byte(8'($urandom)); push_byte(8'($urandom));
        push_byte(8'(hsize >> 24)); push_byte(8'(hsize >> 16));
        push_byte(8'(hsize >> 8)); push_byte(8'(hsize));
        for (int i = 0; i < ((hsize > 9) ? hsize - 9 : 0) + 4; i++)
            push_byte(8'($urandom));
    endfunction

    function automatic void push_tag(logic [7:0] tt, int dsize);
        logic [7:0] first;
        push_byte(tt);
        push_byte(8'(dsize >> 16)); push_byte(8'(dsize >> 8)); push_byte(8'(dsize));
        for (int i = 0; i < 7; i++)
            push_byte(8'($urandom));
        for (int i = 0; i < dsize; i++)
        begin
            first = 8'($urandom);
            // bias media headers toward aac and avc
            if (i == 0 && tt == TAG_AUDIO && $urandom_range(0, 1)) first[7:4] = 4'd10;
            if (i == 0 && tt == TAG_VIDEO && $urandom_range(0, 1)) first[3:0] = 4'd7;
            if (i == 1 && $urandom_range(0, 2) == 0) first = 8'd0;
            push_byte(first);
        end
        for (int i = 0; i < 4; i++)
            push_byte(8'($urandom));
    endfunction

    function automatic void push_random_stream();
        int          ntags;
        int          pick;
        logic [7:0]  tt;
        in_item_t    it;
        ntags = $urandom_range(1, 6);
        push_file_header($urandom_range(0, 4) == 0 ? $urandom_range(0, 14) : 9);
        for (int t = 0; t < ntags; t++)
        begin
            pick = $urandom_range(0, 9);
            tt = (pick < 4) ? TAG_AUDIO : (pick < 8) ? TAG_VIDEO :
                 (pick == 8) ? TAG_SCRIPT : 8'($urandom);
            push_tag(tt, $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) :
                     $urandom_range(0, 24));
        end
        // occasional noise or truncation, then always a flush
        pick = $urandom_range(0, 5);
        if (pick == 0)
            for (int i = 0; i < $urandom_range(1, 12); i++) push_byte(8'($urandom));
        else if (pick == 1 && byte_stream.size() > 8)
            for (int i = 0; i < $urandom_range(1, 6); i++) void'(byte_stream.pop_back());
        it.data_byte = 8'($urandom);
        it.flush = 1'b1;
        byte_stream.push_back(it);
    endfunction

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("flv_tag_deframer_tb NOT OK");
            $finish;
        end
    end

    // receiver: random stalls plus a held-off stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (cycle_count % 3000 < 1000)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 9) < 7) ||
                         ($urandom_range(0, 40) == 0 ? 1'b0 : 1'b0);
    end

    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (400) @(posedge clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind %0d", out_item.kind);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (out_item.kind !== e.kind)
                    $error("kind exp %0d got %0d", e.kind, out_item.kind);
                if (out_item.tag_type !== e.tag_type)
                    $error("tag_type exp %0d got %0d", e.tag_type, out_item.tag_type);
                if (out_item.timestamp !== e.timestamp)
                    $error("timestamp exp %0h got %0h", e.timestamp, out_item.timestamp);
                if (out_item.track !== e.track)
                    $error("track exp %0h got %0h", e.track, out_item.track);
                if (out_item.codec !== e.codec)
                    $error("codec exp %0d got %0d", e.codec, out_item.codec);
                if (out_item.frame_type !== e.frame_type)
                    $error("frame_type exp %0d got %0d", e.frame_type, out_item.frame_type);
                if (out_item.is_config !== e.is_config)
                    $error("is_config exp %0d got %0d", e.is_config, out_item.is_config);
                if (out_item.composition_offset !== e.composition_offset)
                    $error("composition_offset exp %0h got %0h",
                           e.composition_offset, out_item.composition_offset);
                if (out_item.sample_rate !== e.sample_rate)
                    $error("sample_rate exp %0d got %0d", e.sample_rate, out_item.sample_rate);
                if (out_item.channels !== e.channels)
                    $error("channels exp %0d got %0d", e.channels, out_item.channels);
                if (out_item.payload_byte !== e.payload_byte)
                    $error("payload_byte exp %0h got %0h", e.payload_byte, out_item.payload_byte);
                if (out_item.last !== e.last)
                    $error("last exp %0d got %0d", e.last, out_item.last);
                if (out_item !== e)
                    fail_count++;
            end
        end
    end

    // send one byte, predicting its result; typed row results are checked too
    task automatic send_byte(in_item_t it, logic typed, out_item_t typed_res);
        out_item_t r;
        logic      has;
        int        gap;
        gap = ($urandom_range(0, 3) == 0) ?
              (($urandom_range(0, 15) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 2)) : 0;
        if (cycle_count % 3000 >= 2000) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        has = parse_byte(it, r);
        if (typed && (!has || r !== typed_res))
        begin
            $error("directed row prediction exp %h got %h", typed_res, r);
            fail_count++;
        end
        if (has) expected_results.push_back(r);
    endtask

    // stimulus
    initial
    begin
        row_t       rows[$];
        row_t       rw;
        out_item_t  w;
        in_item_t   it;
        int         wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        fail_count = 0;
        parser_reset();
        w = '0;
        w.kind = KIND_WARN;
        // directed: warning after reset, its re-arm by flush, then a closing flush
        rw = '{8'hFF, 1'b0, 1'b0, '0}; rows.push_back(rw);
        rw = '{8'h00, 1'b0, 1'b0, '0}; rows.push_back(rw);
        rw = '{8'h00, 1'b0, 1'b1, w};  rows.push_back(rw);
        rw = '{8'h46, 1'b0, 1'b0, '0}; rows.push_back(rw);
        rw = '{8'hFF, 1'b1, 1'b0, '0}; rows.push_back(rw);
        rw = '{8'hFF, 1'b0, 1'b0, '0}; rows.push_back(rw);
        rw = '{8'h80, 1'b0, 1'b0, '0}; rows.push_back(rw);
        rw = '{8'h01, 1'b0, 1'b1, w};  rows.push_back(rw);
        rw = '{8'h00, 1'b1, 1'b0, '0}; rows.push_back(rw);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            it.data_byte = rows[i].b;
            it.flush = rows[i].fl;
            send_byte(it, rows[i].typed, rows[i].res);
        end
        // directed streams: small header size, empty audio and video tags,
        // short video and audio tags, script and unknown tags
        push_file_header(0);
        push_tag(TAG_AUDIO, 0);
        push_tag(TAG_VIDEO, 0);
        push_tag(TAG_VIDEO, 1);
        push_tag(TAG_VIDEO, 3);
        push_tag(TAG_AUDIO, 1);
        push_tag(TAG_SCRIPT, 0);
        push_tag(8'hFF, 2);
        while (byte_stream.size() != 0)
            send_byte(byte_stream.pop_front(), 1'b0, '0);
        // random streams
        for (int n = 0; n < 1700; )
        begin
            push_random_stream();
            n += byte_stream.size();
            while (byte_stream.size() != 0)
                send_byte(byte_stream.pop_front(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("flv_tag_deframer_tb OK");
        else
            $display("flv_tag_deframer_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
sv/flvd_pkg.sv
sv/flvd_parser.sv
sv/flvd_queue.sv
sv/flv_tag_deframer.sv
verif/flv_tag_deframer_tb.sv
